/* rtl/core/pes_header_parser_core_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef PES_HEADER_PARSER_CORE_MACROS_SVH
`define PES_HEADER_PARSER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PHP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define PHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* rtl/core/php_pkg.sv */
//------------------------------------------------------------------------------
// php_pkg
// Types and constants of the program-stream PES header parser.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package php_pkg;

   typedef enum logic [4:0] {
      PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_SKIP, PH_STUFF, PH_BUF1, PH_BUF2,
      PH_M1_PTS, PH_M1_DTS, PH_M2_FLAGS, PH_M2_HLEN, PH_M2_PTS, PH_M2_DTS,
      PH_M2_EXT, PH_M2_ESKIP, PH_M2_E2LEN, PH_M2_IDEXT, PH_M2_HSKIP, PH_PAYLOAD
   } phase_type;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   localparam logic [15:0] CODE_PACK   = 16'h01BA;
   localparam logic [15:0] CODE_SYSTEM = 16'h01BB;
   localparam logic [15:0] CODE_MAP    = 16'h01BC;
   localparam logic [15:0] CODE_PRIV1  = 16'h01BD;
   localparam logic [15:0] CODE_PAD    = 16'h01BE;
   localparam logic [15:0] CODE_PRIV2  = 16'h01BF;
   localparam logic [15:0] CODE_EXTID  = 16'h01FD;
   localparam logic [23:0] SYNC_RESET  = 24'h0000FF;
   localparam logic [23:0] SYNC_PREFIX = 24'h000001;
   localparam logic [31:0] STAMP_NONE  = 32'hFFFFFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] stream_code;
      logic        pts_valid;
      logic [31:0] pts_value;
      logic [31:0] dts_value;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
      logic        last_byte;
   } rsp_type;

   // Timestamp from five shifted bytes, low 32 bits.
   function automatic logic [31:0] stamp_value(input logic [39:0] t);
      logic [32:0] v;
      v = {t[35:33], 30'd0} | {3'd0, t[31:17], 15'd0} | {18'd0, t[15:1]};
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/php_req_if.sv */
//------------------------------------------------------------------------------
// php_req_if
// Valid/ready channel carrying stream bytes into the parser.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface php_req_if;
   import php_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/php_rsp_if.sv */
//------------------------------------------------------------------------------
// php_rsp_if
// Valid/ready channel carrying parser results.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface php_rsp_if;
   import php_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/pes_header_parser_core.sv */
//------------------------------------------------------------------------------
// pes_header_parser_core
// MPEG program-stream PES demultiplexer, one byte per cycle unless its result stalls.
//------------------------------------------------------------------------------
// The parser takes one program-stream byte per cycle and answers each with at
// most one result: a packet header (code, timestamps, payload length), a
// payload byte with a last-byte mark, or an end-of-stream mark. A byte is
// accepted in every cycle while the result register is empty or being drained;
// the result is held in the result register and is valid in the cycle after its
// byte is transferred. Stream end returns all parse state to its reset value.
`timescale 1ns / 1ps
`default_nettype none
`include "pes_header_parser_core_macros.svh"
module pes_header_parser_core (
   input wire logic clock,
   input wire logic reset,
   php_req_if.sink  req_chan,
   php_rsp_if.source rsp_chan
);
   import php_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [23:0]        sync_ff, sync_in;
   logic [15:0]        code_ff, code_in;
   logic signed [16:0] rem_ff, rem_in;
   logic signed [8:0]  hrem_ff, hrem_in;
   logic [7:0]         pflags_ff, pflags_in;
   logic [7:0]         eflags_ff, eflags_in;
   logic [39:0]        ts_ff, ts_in;
   logic [31:0]        pts_ff, pts_in, dts_ff, dts_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               seen_ff, seen_in;
   logic               ovalid_ff;
   rsp_type            out_ff, out_in;
   logic               emit;

   logic               take;
   logic [7:0]         b;
   logic [39:0]        ts_sh;
   logic [4:0]         cnt_dec;
   logic [4:0]         skip;
   logic [31:0]        st;

   assign req_chan.ready   = !ovalid_ff || rsp_chan.ready;
   assign take             = req_chan.valid && req_chan.ready;
   assign b                = req_chan.payload.data_byte;
   assign ts_sh            = {ts_ff[31:0], b};
   assign cnt_dec          = cnt_ff - 5'd1;
   assign st               = stamp_value(ts_sh);
   assign rsp_chan.valid   = ovalid_ff;
   assign rsp_chan.payload = out_ff;

   // Per-byte parse step; the helper paths of the header grammar are inlined.
   always_comb begin
      logic signed [16:0] r;
      logic signed [8:0]  h;
      logic [7:0]         pf;
      logic               fin, m2end, aftert, aftere, classify;
      phase_in  = phase_ff;
      sync_in   = sync_ff;
      code_in   = code_ff;
      rem_in    = rem_ff;
      hrem_in   = hrem_ff;
      pflags_in = pflags_ff;
      eflags_in = eflags_ff;
      ts_in     = ts_ff;
      pts_in    = pts_ff;
      dts_in    = dts_ff;
      cnt_in    = cnt_ff;
      seen_in   = seen_ff;
      out_in    = '0;
      emit      = 1'b0;
      fin = 1'b0; m2end = 1'b0; aftert = 1'b0; aftere = 1'b0; classify = 1'b0;
      r  = rem_ff;
      h  = hrem_ff;
      pf = pflags_ff;
      skip = 5'd0;
      case (phase_ff)
         PH_HUNT: begin
            if (sync_ff == SYNC_PREFIX) begin
               code_in = {8'h01, b};
               sync_in = SYNC_RESET;
               if (code_in != CODE_PACK && code_in != CODE_SYSTEM)
                  phase_in = PH_LEN_HI;
            end else begin
               sync_in = {sync_ff[15:0], b};
            end
         end
         PH_LEN_HI: begin
            rem_in   = {1'b0, b, 8'd0};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            r = {rem_ff[16:8], b};
            rem_in = r;
            if (code_ff == CODE_PAD || code_ff == CODE_PRIV2 || code_ff == CODE_MAP) begin
               if (r > 0) phase_in = PH_SKIP;
               else begin phase_in = PH_HUNT; sync_in = SYNC_RESET; end
            end else if ((code_ff >= 16'h01C0 && code_ff <= 16'h01EF) ||
                         code_ff == CODE_PRIV1 || code_ff == CODE_EXTID) begin
               if (r < 1) begin phase_in = PH_HUNT; sync_in = SYNC_RESET; end
               else phase_in = PH_STUFF;
            end else begin
               phase_in = PH_HUNT; sync_in = SYNC_RESET;
            end
         end
         PH_SKIP: begin
            rem_in = rem_ff - 17'sd1;
            if (rem_in <= 0) begin phase_in = PH_HUNT; sync_in = SYNC_RESET; end
         end
         PH_STUFF: begin
            r = rem_ff - 17'sd1;
            rem_in = r;
            if (b == 8'hFF) begin
               if (r < 1) begin phase_in = PH_HUNT; sync_in = SYNC_RESET; end
            end else if (b[7:6] == 2'b01) begin
               rem_in   = r - 17'sd2;
               phase_in = PH_BUF1;
            end else begin
               classify = 1'b1;
            end
         end
         PH_BUF1: phase_in = PH_BUF2;
         PH_BUF2: classify = 1'b1;
         PH_M1_PTS, PH_M1_DTS: begin
            ts_in  = ts_sh;
            cnt_in = cnt_dec;
            if (cnt_dec == 5'd0) begin
               if (phase_ff == PH_M1_PTS) begin
                  pts_in  = st;
                  dts_in  = st;
                  seen_in = 1'b1;
                  if (pflags_ff[4]) begin
                     rem_in   = rem_ff - 17'sd5;
                     cnt_in   = 5'd5;
                     ts_in    = '0;
                     phase_in = PH_M1_DTS;
                  end else fin = 1'b1;
               end else begin
                  dts_in = st;
                  fin    = 1'b1;
               end
            end
         end
         PH_M2_FLAGS: begin
            pflags_in = b;
            phase_in  = PH_M2_HLEN;
         end
         PH_M2_HLEN: begin
            r = rem_ff - 17'sd2;
            rem_in = r;
            if ($signed({9'd0, b}) > r) begin
               phase_in = PH_HUNT; sync_in = SYNC_RESET;
            end else begin
               rem_in  = r - $signed({9'd0, b});
               hrem_in = $signed({1'b0, b});
               h       = $signed({1'b0, b});
               if (pflags_ff[7]) begin
                  cnt_in   = 5'd5;
                  ts_in    = '0;
                  phase_in = PH_M2_PTS;
               end else aftert = 1'b1;
            end
         end
         PH_M2_PTS, PH_M2_DTS: begin
            ts_in  = ts_sh;
            cnt_in = cnt_dec;
            if (cnt_dec == 5'd0) begin
               h = hrem_ff - 9'sd5;
               hrem_in = h;
               if (phase_ff == PH_M2_PTS) begin
                  pts_in  = st;
                  dts_in  = st;
                  seen_in = 1'b1;
                  if (pflags_ff[6]) begin
                     cnt_in   = 5'd5;
                     ts_in    = '0;
                     phase_in = PH_M2_DTS;
                  end else aftert = 1'b1;
               end else begin
                  dts_in = st;
                  aftert = 1'b1;
               end
            end
         end
         PH_M2_EXT: begin
            h = hrem_ff - 9'sd1;
            // Skip count reaches up to 20 bytes, so it needs five bits.
            skip = {1'b0, b[7:4] & 4'hB};
            skip = skip + (skip & 5'h09);
            if (b[6] || $signed({4'd0, skip}) > h) begin
               eflags_in = 8'd0;
               hrem_in   = h;
               m2end     = 1'b1;
            end else begin
               eflags_in = b;
               h = h - $signed({4'd0, skip});
               hrem_in = h;
               if (skip != 5'd0) begin
                  cnt_in   = skip;
                  phase_in = PH_M2_ESKIP;
               end else aftere = 1'b1;
            end
         end
         PH_M2_ESKIP: begin
            cnt_in = cnt_dec;
            if (cnt_dec == 5'd0) aftere = 1'b1;
         end
         PH_M2_E2LEN: begin
            h = hrem_ff - 9'sd1;
            hrem_in = h;
            if (b[6:0] != 7'd0) phase_in = PH_M2_IDEXT;
            else m2end = 1'b1;
         end
         PH_M2_IDEXT: begin
            if (!b[7]) code_in = {code_ff[7:0], 8'd0};
            h = hrem_ff - 9'sd1;
            hrem_in = h;
            m2end = 1'b1;
         end
         PH_M2_HSKIP: begin
            h = hrem_ff - 9'sd1;
            hrem_in = h;
            if (h <= 0) fin = 1'b1;
         end
         PH_PAYLOAD: begin
            r = rem_ff - 17'sd1;
            rem_in = r;
            emit = 1'b1;
            out_in.kind         = KIND_PAYLOAD;
            out_in.stream_code  = code_ff;
            out_in.payload_byte = b;
            out_in.last_byte    = (r <= 0);
            if (r <= 0) begin phase_in = PH_HUNT; sync_in = SYNC_RESET; end
         end
         default: begin
            phase_in = PH_HUNT;
            sync_in  = SYNC_RESET;
         end
      endcase

      // Marker byte after stuffing or buffer fields.
      if (classify) begin
         pts_in  = STAMP_NONE;
         dts_in  = STAMP_NONE;
         seen_in = 1'b0;
         if (b[7:5] == 3'b001) begin
            ts_in     = {32'd0, b};
            pflags_in = b;
            cnt_in    = 5'd4;
            rem_in    = r - 17'sd4;
            phase_in  = PH_M1_PTS;
         end else if (b[7:6] == 2'b10) begin
            phase_in = PH_M2_FLAGS;
         end else if (b == 8'h0F) begin
            fin = 1'b1;
         end else begin
            phase_in = PH_HUNT; sync_in = SYNC_RESET;
         end
      end

      // After timestamps: trim flags, then optional extension.
      if (aftert) begin
         pf = pflags_ff;
         if (pf[5:0] != 6'd0 && h == 0) pf = pf & 8'hC0;
         pflags_in = pf;
         if (pf[0]) phase_in = PH_M2_EXT;
         else m2end = 1'b1;
      end
      if (aftere) begin
         if (eflags_in[0]) phase_in = PH_M2_E2LEN;
         else m2end = 1'b1;
      end
      if (m2end) begin
         if (h < 0) begin phase_in = PH_HUNT; sync_in = SYNC_RESET; end
         else if (h == 0) fin = 1'b1;
         else phase_in = PH_M2_HSKIP;
      end

      // Header result, or resync on negative payload length.
      if (fin) begin
         sync_in = SYNC_RESET;
         if (rem_in < 0) begin
            phase_in = PH_HUNT;
         end else begin
            emit = 1'b1;
            out_in.kind           = KIND_HEADER;
            out_in.stream_code    = code_in;
            out_in.pts_valid      = seen_in;
            out_in.pts_value      = pts_in;
            out_in.dts_value      = dts_in;
            out_in.payload_length = rem_in[15:0];
            phase_in = (rem_in > 0) ? PH_PAYLOAD : PH_HUNT;
         end
      end

      // End of stream overrides everything.
      if (req_chan.payload.end_of_stream) begin
         phase_in = PH_HUNT; sync_in = SYNC_RESET; code_in = '0; rem_in = '0;
         hrem_in = '0; pflags_in = '0; eflags_in = '0; ts_in = '0;
         pts_in = STAMP_NONE; dts_in = STAMP_NONE; cnt_in = '0; seen_in = 1'b0;
         out_in = '0;
         out_in.kind = KIND_END;
         emit = 1'b1;
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT; sync_ff <= SYNC_RESET; code_ff <= '0; rem_ff <= '0;
         hrem_ff <= '0; pflags_ff <= '0; eflags_ff <= '0; ts_ff <= '0;
         pts_ff <= STAMP_NONE; dts_ff <= STAMP_NONE; cnt_ff <= '0; seen_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in; sync_ff <= sync_in; code_ff <= code_in;
         rem_ff <= rem_in; hrem_ff <= hrem_in; pflags_ff <= pflags_in;
         eflags_ff <= eflags_in; ts_ff <= ts_in; pts_ff <= pts_in;
         dts_ff <= dts_in; cnt_ff <= cnt_in; seen_ff <= seen_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         ovalid_ff <= take && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) out_ff <= out_in;
   end

   `PHP_ASSERT_IMP(a_stall_blocks, clock, reset, ovalid_ff && !rsp_chan.ready,
      !req_chan.ready, "input taken while result stalled")
   `PHP_ASSERT_NEXT(a_end_resets, clock, reset, take && req_chan.payload.end_of_stream,
      phase_ff == PH_HUNT && ovalid_ff, "end of stream did not reset")
   `PHP_ASSERT_IMP(a_payload_kind, clock, reset, ovalid_ff && out_ff.kind == KIND_PAYLOAD,
      !out_ff.pts_valid, "payload result with timestamp flag")

endmodule
`default_nettype wire
